>>> rtl/ttf_pkg.sv
// Package for the triangle tangent frame block.
// Holds the beat types, the job type passed from front to back, and widths.
// No dependencies.
`timescale 1ns / 1ps

package ttf_pkg;

  // Field and datapath widths.
  localparam int PW      = 16;  // input field width
  localparam int DW      = 17;  // edge and texture delta width
  localparam int PRODW   = 34;  // product of two deltas
  localparam int VW      = 35;  // difference of two products
  localparam int NW      = 30;  // magnitude after range alignment
  localparam int SQW     = 60;  // square of an aligned magnitude
  localparam int SUMW    = 64;  // sum of squares and root iteration
  localparam int LENW    = 31;  // vector length
  localparam int QW      = 15;  // quotient bits of a normalized component
  localparam int NUMW    = 45;  // dividend width
  localparam int OW      = 16;  // output component width
  localparam int ONE_Q14 = 16384;

  // Default depth of the job queue between front and back.
  localparam int JOB_DEPTH = 2;

  // One input vertex.
  typedef struct packed {
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_z;
    logic signed [PW-1:0] tex_u;
    logic signed [PW-1:0] tex_v;
  } vertex_t;

  // One output corner of a frame.
  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic signed [OW-1:0] tangent_x;
    logic signed [OW-1:0] tangent_y;
    logic signed [OW-1:0] tangent_z;
    logic signed [OW-1:0] bitangent_x;
    logic signed [OW-1:0] bitangent_y;
    logic signed [OW-1:0] bitangent_z;
    logic                 degenerate;
    logic                 last_corner;
  } frame_t;

  // Edge vectors and texture deltas of one triangle.
  typedef struct packed {
    logic signed [DW-1:0] e0x;
    logic signed [DW-1:0] e0y;
    logic signed [DW-1:0] e0z;
    logic signed [DW-1:0] e1x;
    logic signed [DW-1:0] e1y;
    logic signed [DW-1:0] e1z;
    logic signed [DW-1:0] du0;
    logic signed [DW-1:0] du1;
    logic signed [DW-1:0] dv0;
    logic signed [DW-1:0] dv1;
  } job_t;

endpackage

>>> rtl/ttf_front.sv
// Front end of the triangle tangent frame block: holds the first two corners
// of a triangle and forms edge and texture deltas on the third.
// Depends on ttf_pkg.
`timescale 1ns / 1ps

module ttf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ttf_pkg::vertex_t in_beat_i,
  output logic            job_push_o,
  output ttf_pkg::job_t   job_o,
  input  logic            job_full_i
);
  import ttf_pkg::*;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] phase_q, phase_d;
  vertex_t    v0_q, v1_q;
  logic       accept;

  // Only the third corner needs room in the queue.
  assign in_stall_o = (phase_q == PH_THIRD) && job_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign job_push_o = accept && (phase_q == PH_THIRD);

  // Deltas against the first corner, sign extended by one bit.
  assign job_o.e0x = {v1_q.pos_x[PW-1], v1_q.pos_x} - {v0_q.pos_x[PW-1], v0_q.pos_x};
  assign job_o.e0y = {v1_q.pos_y[PW-1], v1_q.pos_y} - {v0_q.pos_y[PW-1], v0_q.pos_y};
  assign job_o.e0z = {v1_q.pos_z[PW-1], v1_q.pos_z} - {v0_q.pos_z[PW-1], v0_q.pos_z};
  assign job_o.e1x = {in_beat_i.pos_x[PW-1], in_beat_i.pos_x}
                   - {v0_q.pos_x[PW-1], v0_q.pos_x};
  assign job_o.e1y = {in_beat_i.pos_y[PW-1], in_beat_i.pos_y}
                   - {v0_q.pos_y[PW-1], v0_q.pos_y};
  assign job_o.e1z = {in_beat_i.pos_z[PW-1], in_beat_i.pos_z}
                   - {v0_q.pos_z[PW-1], v0_q.pos_z};
  assign job_o.du0 = {v1_q.tex_u[PW-1], v1_q.tex_u} - {v0_q.tex_u[PW-1], v0_q.tex_u};
  assign job_o.du1 = {in_beat_i.tex_u[PW-1], in_beat_i.tex_u}
                   - {v0_q.tex_u[PW-1], v0_q.tex_u};
  assign job_o.dv0 = {v1_q.tex_v[PW-1], v1_q.tex_v} - {v0_q.tex_v[PW-1], v0_q.tex_v};
  assign job_o.dv1 = {in_beat_i.tex_v[PW-1], in_beat_i.tex_v}
                   - {v0_q.tex_v[PW-1], v0_q.tex_v};

  // Corner phase sequencing; the unused code restarts a triangle.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_SECOND: phase_d = PH_THIRD;
        PH_THIRD:  phase_d = PH_FIRST;
        default:   phase_d = PH_SECOND;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Held corners.
  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PH_SECOND) begin
      v1_q <= in_beat_i;
    end
    if (accept && phase_q != PH_SECOND && phase_q != PH_THIRD) begin
      v0_q <= in_beat_i;
    end
  end

endmodule

>>> rtl/ttf_queue.sv
// Short job queue between the front and back ends of the tangent frame block.
// Depends on ttf_pkg.
`timescale 1ns / 1ps

module ttf_queue #(
  parameter int Depth = ttf_pkg::JOB_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ttf_pkg::job_t job_o
);
  import ttf_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ttf_back.sv
// Back end of the tangent frame block: products on one shared multiplier,
// then range alignment, root and division for each of the three vectors.
// Depends on ttf_pkg.
`timescale 1ns / 1ps

module ttf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  ttf_pkg::job_t   job_i,
  output logic            job_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ttf_pkg::frame_t out_beat_o
);
  import ttf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_SQ    = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  localparam logic [4:0] MUL_LAST  = 5'd20;
  localparam logic [4:0] SQ_LAST   = 5'd4;
  localparam logic [4:0] ROOT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd15;

  logic [2:0]              state_q;
  logic [4:0]              cnt_q;
  logic [1:0]              vec_q, comp_q, corner_q;
  logic                    bad_q;
  job_t                    job_q;

  // Product pipeline.
  logic signed [DW-1:0]    op_a, op_b;
  logic signed [PRODW-1:0] mul_q, first_q;
  logic [4:0]              mk_q;
  logic                    mv_q;
  logic signed [VW-1:0]    diff;
  logic signed [VW-1:0]    det_q;
  logic signed [VW-1:0]    raw_q [9];

  // Alignment, root and division.
  logic [VW-1:0]           m_q [3];
  logic                    neg_q [3];
  logic [VW-1:0]           max_q;
  logic [VW-1:0]           mag [3];
  logic [VW-1:0]           mag_max;
  logic [SQW-1:0]          sq_q;
  logic                    sv_q;
  logic [SUMW-1:0]         sum_q, rem_q, root_q, bit_q, trial;
  logic [LENW-1:0]         len;
  logic [NUMW-1:0]         num;
  logic [31:0]             r_q, r_try;
  logic [QW-1:0]           low_q, q_q, q_next;
  logic [QW-1:0]           q_clamp;
  logic signed [OW-1:0]    comp_val;
  logic signed [OW-1:0]    res_q [9];
  logic                    out_valid_q;
  frame_t                  out_q;

  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // Operand pairs, chosen by the product being issued this cycle; each
  // result is first product minus second product.
  always_comb begin
    op_a = job_q.du0;
    op_b = job_q.dv1;
    unique case (cnt_q)
      5'd0:    begin op_a = job_q.du0; op_b = job_q.dv1; end
      5'd1:    begin op_a = job_q.du1; op_b = job_q.dv0; end
      5'd2:    begin op_a = job_q.e0y; op_b = job_q.e1z; end
      5'd3:    begin op_a = job_q.e0z; op_b = job_q.e1y; end
      5'd4:    begin op_a = job_q.e0z; op_b = job_q.e1x; end
      5'd5:    begin op_a = job_q.e0x; op_b = job_q.e1z; end
      5'd6:    begin op_a = job_q.e0x; op_b = job_q.e1y; end
      5'd7:    begin op_a = job_q.e0y; op_b = job_q.e1x; end
      5'd8:    begin op_a = job_q.e0x; op_b = job_q.dv1; end
      5'd9:    begin op_a = job_q.e1x; op_b = job_q.dv0; end
      5'd10:   begin op_a = job_q.e0y; op_b = job_q.dv1; end
      5'd11:   begin op_a = job_q.e1y; op_b = job_q.dv0; end
      5'd12:   begin op_a = job_q.e0z; op_b = job_q.dv1; end
      5'd13:   begin op_a = job_q.e1z; op_b = job_q.dv0; end
      5'd14:   begin op_a = job_q.e1x; op_b = job_q.du0; end
      5'd15:   begin op_a = job_q.e0x; op_b = job_q.du1; end
      5'd16:   begin op_a = job_q.e1y; op_b = job_q.du0; end
      5'd17:   begin op_a = job_q.e0y; op_b = job_q.du1; end
      5'd18:   begin op_a = job_q.e1z; op_b = job_q.du0; end
      5'd19:   begin op_a = job_q.e0z; op_b = job_q.du1; end
      default: begin op_a = job_q.du0; op_b = job_q.dv1; end
    endcase
  end

  assign diff = {first_q[PRODW-1], first_q} - {mul_q[PRODW-1], mul_q};

  // Magnitudes of the three raw components at the head of the line.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = raw_q[i][VW-1] ? VW'(-raw_q[i]) : VW'(raw_q[i]);
    end
    mag_max = mag[0];
    if (mag[1] > mag_max) mag_max = mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
  end

  // One step of the square root.
  assign trial = root_q + bit_q;

  // One step of the division, dividend bits fed from low_q.
  assign len    = root_q[LENW-1:0];
  assign num    = {1'b0, m_q[0][NW-1:0], 14'd0} + NUMW'(len >> 1);
  assign r_try  = {r_q[30:0], low_q[QW-1]};
  assign q_next = {q_q[QW-2:0], (r_try >= {1'b0, len})};
  assign q_clamp = (q_next > QW'(ONE_Q14)) ? QW'(ONE_Q14) : q_next;
  assign comp_val = neg_q[0] ? -OW'(q_clamp) : OW'(q_clamp);

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      vec_q       <= '0;
      comp_q      <= '0;
      corner_q    <= '0;
      bad_q       <= 1'b0;
      mv_q        <= 1'b0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
            bad_q   <= 1'b0;
          end
        end
        S_MUL: begin
          mv_q  <= (cnt_q != MUL_LAST);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MUL_LAST) begin
            state_q <= S_LOAD;
            vec_q   <= '0;
          end
        end
        S_LOAD: begin
          if (vec_q == 2'd0 && det_q == '0) begin
            bad_q <= 1'b1;
          end
          if (mag_max == '0) begin
            // Zero vector: nothing to normalize, the frame is degenerate.
            bad_q <= 1'b1;
            if (vec_q == 2'd2) begin
              state_q  <= S_EMIT;
              corner_q <= '0;
            end else begin
              vec_q <= vec_q + 1'b1;
            end
          end else begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (max_q[VW-1:NW] == '0 && max_q[NW-1]) begin
            state_q <= S_SQ;
            cnt_q   <= '0;
          end
        end
        S_SQ: begin
          sv_q  <= (cnt_q < 5'd3);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SQ_LAST) begin
            state_q <= S_SQRT;
            cnt_q   <= '0;
          end
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ROOT_LAST) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
            comp_q  <= '0;
          end
        end
        S_DIV: begin
          if (cnt_q == DIV_LAST) begin
            cnt_q <= '0;
            if (comp_q == 2'd2) begin
              if (vec_q == 2'd2) begin
                state_q  <= S_EMIT;
                corner_q <= '0;
              end else begin
                vec_q   <= vec_q + 1'b1;
                state_q <= S_LOAD;
              end
            end else begin
              comp_q <= comp_q + 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
          end else if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (corner_q == 2'd2) begin
              state_q <= S_IDLE;
            end else begin
              corner_q <= corner_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end

    // Shared product multiplier and difference stage.
    if (state_q == S_MUL && cnt_q != MUL_LAST) begin
      mul_q <= op_a * op_b;
    end
    if (state_q == S_MUL) begin
      mk_q <= cnt_q;
    end
    if (mv_q) begin
      if (!mk_q[0]) begin
        first_q <= mul_q;
      end else if (mk_q == 5'd1) begin
        det_q <= diff;
      end else begin
        for (int j = 0; j < 8; j++) raw_q[j] <= raw_q[j+1];
        raw_q[8] <= diff;
      end
    end

    // Take the next vector off the line and record its signs.
    if (state_q == S_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i]   <= mag[i];
        neg_q[i] <= raw_q[i][VW-1] ^ ((vec_q != 2'd0) && det_q[VW-1]);
      end
      max_q <= mag_max;
      for (int j = 0; j < 6; j++) raw_q[j] <= raw_q[j+3];
    end

    // Bring the largest magnitude into [2^29, 2^30).
    if (state_q == S_SHIFT) begin
      if (max_q[VW-1:NW] != '0) begin
        for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        max_q <= max_q >> 1;
      end else if (!max_q[NW-1]) begin
        for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        max_q <= max_q << 1;
      end
    end

    // Sum of squares.
    if (state_q == S_SQ) begin
      if (cnt_q < 5'd3) begin
        sq_q <= m_q[cnt_q[1:0]][NW-1:0] * m_q[cnt_q[1:0]][NW-1:0];
      end
      if (cnt_q == '0) begin
        sum_q <= '0;
      end else if (sv_q) begin
        sum_q <= sum_q + SUMW'(sq_q);
      end
      if (cnt_q == SQ_LAST) begin
        rem_q  <= sum_q;
        root_q <= '0;
        bit_q  <= SUMW'(1) << (SUMW - 2);
      end
    end

    // Integer square root, one result bit a cycle.
    if (state_q == S_SQRT) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    // Rounded division by the length, one quotient bit a cycle.
    if (state_q == S_DIV) begin
      if (cnt_q == '0) begin
        r_q   <= {2'b00, num[NUMW-1:QW]};
        low_q <= num[QW-1:0];
        q_q   <= '0;
      end else begin
        r_q   <= q_next[0] ? (r_try - {1'b0, len}) : r_try;
        low_q <= low_q << 1;
        q_q   <= q_next;
      end
      if (cnt_q == DIV_LAST) begin
        for (int j = 0; j < 8; j++) res_q[j] <= res_q[j+1];
        res_q[8] <= comp_val;
        m_q[0]   <= m_q[1];
        m_q[1]   <= m_q[2];
        m_q[2]   <= m_q[0];
        neg_q[0] <= neg_q[1];
        neg_q[1] <= neg_q[2];
        neg_q[2] <= neg_q[0];
      end
    end

    // Output beat, zeroed when the frame is degenerate.
    if (state_q == S_EMIT && !out_valid_q) begin
      out_q.normal_x    <= bad_q ? '0 : res_q[0];
      out_q.normal_y    <= bad_q ? '0 : res_q[1];
      out_q.normal_z    <= bad_q ? '0 : res_q[2];
      out_q.tangent_x   <= bad_q ? '0 : res_q[3];
      out_q.tangent_y   <= bad_q ? '0 : res_q[4];
      out_q.tangent_z   <= bad_q ? '0 : res_q[5];
      out_q.bitangent_x <= bad_q ? '0 : res_q[6];
      out_q.bitangent_y <= bad_q ? '0 : res_q[7];
      out_q.bitangent_z <= bad_q ? '0 : res_q[8];
      out_q.degenerate  <= bad_q;
      out_q.last_corner <= (corner_q == 2'd2);
    end
  end

endmodule

>>> rtl/triangle_tangent_frame_core.sv
// Top level of the per-face tangent frame block.
// Depends on ttf_pkg, ttf_front, ttf_queue and ttf_back.
//
// Usage: vertices arrive on the input channel (in_valid_i, in_stall_o,
// in_beat_i), three per triangle. The first two are held; the third forms
// the edge and texture deltas, which go into a short job queue. The back end
// takes jobs from the queue and sends three frame beats per triangle on the
// output channel (out_valid_o, out_stall_i, out_beat_o), the third with
// last_corner set.
// Throughput: vertices are taken one a cycle while the job queue has room.
// The back end forms its products on the shared multiplier, then per
// vector loads and range-aligns, sums squares, takes the square root and
// divides, its time per triangle set by the bit-serial root and divider;
// a zero vector skips its normalization. It takes a new job from the queue
// only once it has sent all three frame beats of the last.
// Reset clears the corner phase, the queue and the back end state.
// When the receiver stalls the beat holds; once the queue is full the third
// vertex of the next triangle is stalled.
`timescale 1ns / 1ps

module triangle_tangent_frame_core #(
  parameter int JobDepth = ttf_pkg::JOB_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ttf_pkg::vertex_t in_beat_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ttf_pkg::frame_t  out_beat_o
);
  import ttf_pkg::*;

  logic job_push, job_full, job_pop, job_valid;
  job_t job_in, job_out;

  ttf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  ttf_queue #(
    .Depth (JobDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  ttf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

>>> rtl/ttf_checker.sv
// Port-level checks for the tangent frame block, bound to its top level.
// Depends on ttf_pkg and triangle_tangent_frame_core.
`timescale 1ns / 1ps

module ttf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input ttf_pkg::frame_t out_beat_o
);
  import ttf_pkg::*;

  // A stalled beat stays valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled beat keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("output payload changed while stalled");

  // A degenerate frame carries zero vectors.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.degenerate |->
      out_beat_o.normal_x == '0 && out_beat_o.normal_y == '0 &&
      out_beat_o.normal_z == '0 && out_beat_o.tangent_x == '0 &&
      out_beat_o.tangent_y == '0 && out_beat_o.tangent_z == '0 &&
      out_beat_o.bitangent_x == '0 && out_beat_o.bitangent_y == '0 &&
      out_beat_o.bitangent_z == '0)
    else $error("degenerate frame with nonzero vector");

  // A normalized normal stays within one in Q1.14.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.degenerate |->
      out_beat_o.normal_x <= 16'sd16384 && out_beat_o.normal_x >= -16'sd16384 &&
      out_beat_o.normal_y <= 16'sd16384 && out_beat_o.normal_y >= -16'sd16384 &&
      out_beat_o.normal_z <= 16'sd16384 && out_beat_o.normal_z >= -16'sd16384)
    else $error("normal component out of range");

endmodule

bind triangle_tangent_frame_core ttf_checker u_ttf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
